// File: rtl/lcdn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types, codes and the strobe step table of the nibble sequencer.
// ----------------------------------------------------------------------------
package lcdn_pkg;

   localparam int OP_W     = 4;
   localparam int BYTE_W   = 8;
   localparam int ROW_W    = 2;
   localparam int NIB_W    = 4;
   localparam int WAIT_W   = 19;
   localparam int UNIT_W   = 16;
   localparam int MULT_W   = 3;
   localparam int STEP_W   = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_INIT        = 4'd0;
   localparam logic [OP_W-1:0] OP_CHAR        = 4'd1;
   localparam logic [OP_W-1:0] OP_COMMAND     = 4'd2;
   localparam logic [OP_W-1:0] OP_GOTO        = 4'd3;
   localparam logic [OP_W-1:0] OP_DISPLAY_ON  = 4'd4;
   localparam logic [OP_W-1:0] OP_DISPLAY_OFF = 4'd5;
   localparam logic [OP_W-1:0] OP_CURSOR_AT   = 4'd6;
   localparam logic [OP_W-1:0] OP_CURSOR_OFF  = 4'd7;
   localparam logic [OP_W-1:0] OP_CLEAR       = 4'd8;
   localparam logic [OP_W-1:0] OP_BACKLIGHT   = 4'd9;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_WAIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_WAIT  = 1'b1;

   localparam logic [UNIT_W-1:0] SHORT_WAIT_RESET = 16'd255;
   localparam logic [UNIT_W-1:0] LONG_WAIT_RESET  = 16'd4095;

   localparam logic [BYTE_W-1:0] LINE1_BASE = 8'h80;
   localparam logic [BYTE_W-1:0] LINE2_BASE = 8'hC0;
   localparam logic [ROW_W-1:0]  ROW_LINE2  = 2'd2;

   localparam logic [1:0] NIB_CONST = 2'd0;
   localparam logic [1:0] NIB_HI    = 2'd1;
   localparam logic [1:0] NIB_LO    = 2'd2;

   localparam logic UNIT_SHORT = 1'b0;
   localparam logic UNIT_LONG  = 1'b1;

   typedef struct packed {
      logic              strobe;
      logic              rs;
      logic [1:0]        nib_src;
      logic [NIB_W-1:0]  nib;
      logic [MULT_W-1:0] mult;
      logic              use_long;
      logic              last;
   } step_type;

   function automatic step_type mk_step(input logic strobe, input logic rs,
                                        input logic [1:0] src, input logic [NIB_W-1:0] nib,
                                        input logic [MULT_W-1:0] mult,
                                        input logic use_long, input logic last);
      step_type s;
      s.strobe   = strobe;
      s.rs       = rs;
      s.nib_src  = src;
      s.nib      = nib;
      s.mult     = mult;
      s.use_long = use_long;
      s.last     = last;
      return s;
   endfunction

   // One entry per step (a strobe or a plain wait): what to drive and how many wait units follow it.
   function automatic step_type lcdn_step(input logic [OP_W-1:0] op,
                                          input logic [STEP_W-1:0] idx);
      step_type s;
      logic     hi;
      s  = mk_step(1'b0, 1'b0, NIB_CONST, 4'h0, 3'd0, UNIT_SHORT, 1'b1);
      hi = (idx == 4'd0);
      unique case (op)
         OP_INIT: begin
            unique case (idx)
               4'd0:  s = mk_step(1'b0, 1'b0, NIB_CONST, 4'h0, 3'd5, UNIT_LONG, 1'b0);
               4'd1:  s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h3, 3'd5, UNIT_LONG, 1'b0);
               4'd2:  s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h3, 3'd2, UNIT_SHORT, 1'b0);
               4'd3:  s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h3, 3'd2, UNIT_SHORT, 1'b0);
               4'd4:  s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h2, 3'd1, UNIT_SHORT, 1'b0);
               4'd5:  s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h2, 3'd1, UNIT_SHORT, 1'b0);
               4'd6:  s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h8, 3'd4, UNIT_SHORT, 1'b0);
               4'd7:  s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h0, 3'd1, UNIT_SHORT, 1'b0);
               4'd8:  s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h6, 3'd5, UNIT_SHORT, 1'b0);
               4'd9:  s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h0, 3'd1, UNIT_SHORT, 1'b0);
               4'd10: s = mk_step(1'b1, 1'b0, NIB_CONST, 4'hC, 3'd5, UNIT_SHORT, 1'b0);
               4'd11: s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h0, 3'd1, UNIT_SHORT, 1'b0);
               default: s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h1, 3'd3, UNIT_LONG, 1'b1);
            endcase
         end
         OP_CHAR: begin
            s = hi ? mk_step(1'b1, 1'b1, NIB_HI, 4'h0, 3'd0, UNIT_SHORT, 1'b0)
                   : mk_step(1'b1, 1'b1, NIB_LO, 4'h0, 3'd2, UNIT_SHORT, 1'b1);
         end
         OP_COMMAND: begin
            s = hi ? mk_step(1'b1, 1'b0, NIB_HI, 4'h0, 3'd0, UNIT_SHORT, 1'b0)
                   : mk_step(1'b1, 1'b0, NIB_LO, 4'h0, 3'd5, UNIT_LONG, 1'b1);
         end
         OP_GOTO: begin
            s = hi ? mk_step(1'b1, 1'b0, NIB_HI, 4'h0, 3'd1, UNIT_SHORT, 1'b0)
                   : mk_step(1'b1, 1'b0, NIB_LO, 4'h0, 3'd4, UNIT_SHORT, 1'b1);
         end
         OP_DISPLAY_ON: begin
            s = hi ? mk_step(1'b1, 1'b0, NIB_CONST, 4'h0, 3'd1, UNIT_SHORT, 1'b0)
                   : mk_step(1'b1, 1'b0, NIB_CONST, 4'hC, 3'd3, UNIT_LONG, 1'b1);
         end
         OP_DISPLAY_OFF: begin
            s = hi ? mk_step(1'b1, 1'b0, NIB_CONST, 4'h0, 3'd1, UNIT_SHORT, 1'b0)
                   : mk_step(1'b1, 1'b0, NIB_CONST, 4'h8, 3'd3, UNIT_LONG, 1'b1);
         end
         OP_CURSOR_AT: begin
            unique case (idx)
               4'd0:  s = mk_step(1'b1, 1'b0, NIB_HI, 4'h0, 3'd1, UNIT_SHORT, 1'b0);
               4'd1:  s = mk_step(1'b1, 1'b0, NIB_LO, 4'h0, 3'd4, UNIT_SHORT, 1'b0);
               4'd2:  s = mk_step(1'b1, 1'b0, NIB_CONST, 4'h0, 3'd1, UNIT_SHORT, 1'b0);
               default: s = mk_step(1'b1, 1'b0, NIB_CONST, 4'hF, 3'd5, UNIT_SHORT, 1'b1);
            endcase
         end
         OP_CURSOR_OFF: begin
            s = hi ? mk_step(1'b1, 1'b0, NIB_CONST, 4'h0, 3'd1, UNIT_SHORT, 1'b0)
                   : mk_step(1'b1, 1'b0, NIB_CONST, 4'hC, 3'd5, UNIT_SHORT, 1'b1);
         end
         OP_CLEAR: begin
            s = hi ? mk_step(1'b1, 1'b0, NIB_CONST, 4'h0, 3'd1, UNIT_SHORT, 1'b0)
                   : mk_step(1'b1, 1'b0, NIB_CONST, 4'h1, 3'd3, UNIT_LONG, 1'b1);
         end
         default: begin
            s = mk_step(1'b0, 1'b0, NIB_CONST, 4'h0, 3'd0, UNIT_SHORT, 1'b1);
         end
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// File: rtl/lcdn_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdn_req_if
// Request channel: one display operation with its operands.
// ----------------------------------------------------------------------------
interface lcdn_req_if import lcdn_pkg::*;;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] byte_value;
   logic [ROW_W-1:0]  row;
   logic [BYTE_W-1:0] column;

   modport source (output valid, output operation, output byte_value, output row,
                   output column, input ready);
   modport sink   (input valid, input operation, input byte_value, input row,
                   input column, output ready);
endinterface
`default_nettype wire

// File: rtl/lcdn_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdn_rsp_if
// Result channel: one nibble strobe or wait with its hold-off time.
// ----------------------------------------------------------------------------
interface lcdn_rsp_if import lcdn_pkg::*;;
   logic              valid;
   logic              ready;
   logic              strobe_res;
   logic              reg_select;
   logic [NIB_W-1:0]  nibble;
   logic [WAIT_W-1:0] wait_cycles;
   logic              backlight;
   logic              last;

   modport source (output valid, output strobe_res, output reg_select, output nibble,
                   output wait_cycles, output backlight, output last, input ready);
   modport sink   (input valid, input strobe_res, input reg_select, input nibble,
                   input wait_cycles, input backlight, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/lcdn_csr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdn_csr_if
// Register write channel for the wait unit settings.
// ----------------------------------------------------------------------------
interface lcdn_csr_if import lcdn_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [UNIT_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/char_lcd_nibble_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns one display request into nibble strobes for a 4-bit character bus.
// ----------------------------------------------------------------------------
// A request is taken when idle. Each strobe then passes through a load, k adds in one
// shared adder (k being its wait multiple, 0 to 5), a register step and the handover,
// which output stalls extend. The next request is taken only after the last strobe is
// handed over; an unused code is accepted and dropped while the block stays idle.
// Reset clears control state and the backlight level, loads default units.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer import lcdn_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   lcdn_req_if.sink    req_bus,
   lcdn_rsp_if.source  rsp_bus,
   lcdn_csr_if.sink    csr_bus
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MULT_W-1:0] count_ff, count_in;
   logic [WAIT_W-1:0] acc_ff, acc_in;
   logic              backlight_ff, backlight_in;
   logic [UNIT_W-1:0] short_unit_ff, short_unit_in;
   logic [UNIT_W-1:0] long_unit_ff, long_unit_in;
   logic              out_strobe_ff, out_strobe_in;
   logic              out_rs_ff, out_rs_in;
   logic [NIB_W-1:0]  out_nib_ff, out_nib_in;
   logic [WAIT_W-1:0] out_wait_ff, out_wait_in;
   logic              out_last_ff, out_last_in;

   step_type          desc;
   logic [UNIT_W-1:0] unit;
   logic [BYTE_W-1:0] line_base;
   logic [BYTE_W-1:0] goto_pos;
   logic              req_fire;
   logic              rsp_fire;
   logic              csr_fire;

   assign desc      = lcdn_step(op_ff, step_ff);
   assign unit      = desc.use_long ? long_unit_ff : short_unit_ff;
   assign line_base = (req_bus.row == ROW_LINE2) ? LINE2_BASE : LINE1_BASE;
   assign goto_pos  = line_base + req_bus.column;

   assign req_bus.ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_bus.valid = (state_ff == ST_OUT);
   assign csr_bus.ready = !reset;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign csr_fire = csr_bus.valid && csr_bus.ready;

   assign rsp_bus.strobe_res  = out_strobe_ff;
   assign rsp_bus.reg_select  = out_rs_ff;
   assign rsp_bus.nibble      = out_nib_ff;
   assign rsp_bus.wait_cycles = out_wait_ff;
   assign rsp_bus.backlight   = backlight_ff;
   assign rsp_bus.last        = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      byte_in       = byte_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      backlight_in  = backlight_ff;
      short_unit_in = short_unit_ff;
      long_unit_in  = long_unit_ff;
      out_strobe_in = out_strobe_ff;
      out_rs_in     = out_rs_ff;
      out_nib_in    = out_nib_ff;
      out_wait_in   = out_wait_ff;
      out_last_in   = out_last_ff;

      if (csr_fire) begin
         if (csr_bus.index == CSR_SHORT_WAIT) begin
            short_unit_in = csr_bus.data;
         end else begin
            long_unit_in = csr_bus.data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_bus.operation <= OP_BACKLIGHT)) begin
               op_in   = req_bus.operation;
               step_in = '0;
               if ((req_bus.operation == OP_GOTO) || (req_bus.operation == OP_CURSOR_AT)) begin
                  byte_in = goto_pos;
               end else begin
                  byte_in = req_bus.byte_value;
               end
               if (req_bus.operation == OP_BACKLIGHT) begin
                  backlight_in = req_bus.byte_value[0];
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            acc_in   = '0;
            count_in = desc.mult;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (count_ff == '0) begin
               out_strobe_in = desc.strobe;
               out_rs_in     = desc.rs;
               out_wait_in   = acc_ff;
               out_last_in   = desc.last;
               case (desc.nib_src)
                  NIB_HI:  out_nib_in = byte_ff[7:4];
                  NIB_LO:  out_nib_in = byte_ff[3:0];
                  default: out_nib_in = desc.nib;
               endcase
               state_in = ST_OUT;
            end else begin
               acc_in   = acc_ff + WAIT_W'(unit);
               count_in = count_ff - 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (out_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         backlight_ff  <= 1'b0;
         short_unit_ff <= SHORT_WAIT_RESET;
         long_unit_ff  <= LONG_WAIT_RESET;
         step_ff       <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         backlight_ff  <= backlight_in;
         short_unit_ff <= short_unit_in;
         long_unit_ff  <= long_unit_in;
         step_ff       <= step_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      byte_ff       <= byte_in;
      acc_ff        <= acc_in;
      out_strobe_ff <= out_strobe_in;
      out_rs_ff     <= out_rs_in;
      out_nib_ff    <= out_nib_in;
      out_wait_ff   <= out_wait_in;
      out_last_ff   <= out_last_in;
   end

   // The final strobe of a request returns the block to accepting requests.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && out_last_ff) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after the last strobe");

   // The step counter never runs past the longest sequence.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (step_ff <= 4'd12))
      else $error("step counter ran past the init sequence");

   // The backlight level only changes on an accepted backlight request.
   assert property (@(posedge clock) disable iff (reset)
      !$stable(backlight_ff) |-> $past(req_fire && (req_bus.operation == OP_BACKLIGHT)))
      else $error("backlight changed without a backlight request");

endmodule
`default_nettype wire

// File: test/char_lcd_nibble_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_test
// Self-checking bench for the character display nibble sequencer. Display
// requests go in over the request channel and a scoreboard works out the
// strobes that each one should produce under the current wait units. Every
// strobe that comes out is compared field by field, in order, with the
// oldest expected one. A directed pass covers every operation and the corner
// cases. Random requests then run under several wait settings and idling
// mixes, including a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_test;
   import lcdn_pkg::*;

   localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd10;
   localparam logic [OP_W-1:0] OP_LAST_CODE    = 4'd15;
   localparam int ITEMS_PER_PHASE = 18;
   localparam int PHASE_COUNT     = 5;
   localparam int LONG_HOLD       = 400;
   localparam int IDLE_SETTLE     = 16;

   typedef struct packed {
      logic              strobe;
      logic              rs;
      logic [NIB_W-1:0]  nib;
      logic [WAIT_W-1:0] wait_cycles;
      logic              backlight;
      logic              last;
   } strobe_t;

   class strobe_board;
      strobe_t           expected_q[$];
      logic [UNIT_W-1:0] short_unit;
      logic [UNIT_W-1:0] long_unit;
      logic              backlight_on;
      int                errors;
      int                checked;

      function new();
         short_unit   = SHORT_WAIT_RESET;
         long_unit    = LONG_WAIT_RESET;
         backlight_on = 1'b0;
         errors       = 0;
         checked      = 0;
      endfunction

      function void set_unit(logic [CSR_IDX_W-1:0] idx, logic [UNIT_W-1:0] value);
         if (idx == CSR_SHORT_WAIT) begin
            short_unit = value;
         end else begin
            long_unit = value;
         end
      endfunction

      function void push(logic strobe, logic rs, logic [NIB_W-1:0] nib,
                         int unsigned mult, logic use_long);
         strobe_t s;
         s.strobe      = strobe;
         s.rs          = rs;
         s.nib         = nib;
         s.wait_cycles = WAIT_W'(mult * ((use_long == UNIT_LONG) ? long_unit : short_unit));
         s.backlight   = backlight_on;
         s.last        = 1'b0;
         expected_q.push_back(s);
      endfunction

      function void push_byte(logic rs, logic [BYTE_W-1:0] value, int unsigned mult_hi,
                              logic long_hi, int unsigned mult_lo, logic long_lo);
         push(1'b1, rs, value[7:4], mult_hi, long_hi);
         push(1'b1, rs, value[3:0], mult_lo, long_lo);
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] bv,
                                 logic [ROW_W-1:0] row, logic [BYTE_W-1:0] col);
         int unsigned       depth0;
         logic [BYTE_W-1:0] pos;
         strobe_t           tail;
         depth0 = expected_q.size();
         pos    = ((row == ROW_LINE2) ? LINE2_BASE : LINE1_BASE) + col;
         case (op)
            OP_INIT: begin
               push(1'b0, 1'b0, 4'h0, 5, UNIT_LONG);
               push(1'b1, 1'b0, 4'h3, 5, UNIT_LONG);
               push(1'b1, 1'b0, 4'h3, 2, UNIT_SHORT);
               push(1'b1, 1'b0, 4'h3, 2, UNIT_SHORT);
               push(1'b1, 1'b0, 4'h2, 1, UNIT_SHORT);
               push_byte(1'b0, 8'h28, 1, UNIT_SHORT, 4, UNIT_SHORT);
               push_byte(1'b0, 8'h06, 1, UNIT_SHORT, 5, UNIT_SHORT);
               push_byte(1'b0, 8'h0C, 1, UNIT_SHORT, 5, UNIT_SHORT);
               push_byte(1'b0, 8'h01, 1, UNIT_SHORT, 3, UNIT_LONG);
            end
            OP_CHAR:        push_byte(1'b1, bv, 0, UNIT_SHORT, 2, UNIT_SHORT);
            OP_COMMAND:     push_byte(1'b0, bv, 0, UNIT_SHORT, 5, UNIT_LONG);
            OP_GOTO:        push_byte(1'b0, pos, 1, UNIT_SHORT, 4, UNIT_SHORT);
            OP_DISPLAY_ON:  push_byte(1'b0, 8'h0C, 1, UNIT_SHORT, 3, UNIT_LONG);
            OP_DISPLAY_OFF: push_byte(1'b0, 8'h08, 1, UNIT_SHORT, 3, UNIT_LONG);
            OP_CURSOR_AT: begin
               push_byte(1'b0, pos, 1, UNIT_SHORT, 4, UNIT_SHORT);
               push_byte(1'b0, 8'h0F, 1, UNIT_SHORT, 5, UNIT_SHORT);
            end
            OP_CURSOR_OFF:  push_byte(1'b0, 8'h0C, 1, UNIT_SHORT, 5, UNIT_SHORT);
            OP_CLEAR:       push_byte(1'b0, 8'h01, 1, UNIT_SHORT, 3, UNIT_LONG);
            OP_BACKLIGHT: begin
               backlight_on = bv[0];
               push(1'b0, 1'b0, 4'h0, 0, UNIT_SHORT);
            end
            default: ;
         endcase
         if (expected_q.size() > depth0) begin
            tail      = expected_q.pop_back();
            tail.last = 1'b1;
            expected_q.push_back(tail);
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_strobe(strobe_t got);
         strobe_t want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: strobe with nothing expected, expected none, actual nibble %0h wait %0d",
                     $time, got.nib, got.wait_cycles);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("strobe_res", want.strobe, got.strobe);
         compare_field("reg_select", want.rs, got.rs);
         compare_field("nibble", want.nib, got.nib);
         compare_field("wait_cycles", want.wait_cycles, got.wait_cycles);
         compare_field("backlight", want.backlight, got.backlight);
         compare_field("last", want.last, got.last);
      endfunction

      function void close();
         if (expected_q.size() != 0) begin
            errors++;
            $display("%0t: strobes left over, expected 0, actual %0d", $time, expected_q.size());
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   lcdn_req_if  req_bus ();
   lcdn_rsp_if  rsp_bus ();
   lcdn_csr_if  csr_bus ();
   strobe_board board;
   int          rsp_stall_pct = 0;
   int          hold_requests = 0;
   int          requests_sent = 0;
   int          ignored_sent  = 0;
   int          settings_used = 0;

   char_lcd_nibble_sequencer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] bv,
                            input logic [ROW_W-1:0] row, input logic [BYTE_W-1:0] col,
                            input int gap_pct);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.byte_value <= bv;
      req_bus.row        <= row;
      req_bus.column     <= col;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(op, bv, row, col);
      requests_sent++;
      if (op > OP_BACKLIGHT) begin
         ignored_sent++;
      end
   endtask

   task automatic send_random_requests(input int count, input int gap_pct);
      logic [OP_W-1:0] op;
      int unsigned     pick;
      int              counted;
      counted = 0;
      while (counted < count) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
         end else if (pick < 13) begin
            op = OP_INIT;
         end else begin
            op = OP_W'($urandom_range(OP_CHAR, OP_BACKLIGHT));
         end
         send_item(op, BYTE_W'($urandom_range(255)), ROW_W'($urandom_range(3)),
                   BYTE_W'($urandom_range(255)), gap_pct);
         if (op <= OP_BACKLIGHT) begin
            counted++;
         end
      end
   endtask

   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_units(input logic [UNIT_W-1:0] short_value,
                              input logic [UNIT_W-1:0] long_value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_SHORT_WAIT;
      csr_bus.data  <= short_value;
      do @(posedge clock); while (!csr_bus.ready);
      board.set_unit(CSR_SHORT_WAIT, short_value);
      csr_bus.index <= CSR_LONG_WAIT;
      csr_bus.data  <= long_value;
      do @(posedge clock); while (!csr_bus.ready);
      board.set_unit(CSR_LONG_WAIT, long_value);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_directed();
      send_item(OP_INIT, 8'h00, 2'd0, 8'h00, 0);
      send_item(OP_CHAR, 8'h00, 2'd0, 8'h00, 0);
      send_item(OP_CHAR, 8'hFF, 2'd3, 8'hFF, 0);
      send_item(OP_CHAR, 8'hA5, 2'd1, 8'h5A, 0);
      send_item(OP_COMMAND, 8'h00, 2'd0, 8'h00, 0);
      send_item(OP_COMMAND, 8'hFF, 2'd0, 8'h00, 0);
      send_item(OP_GOTO, 8'h00, 2'd0, 8'h00, 0);
      send_item(OP_GOTO, 8'h00, 2'd2, 8'h3F, 0);
      send_item(OP_GOTO, 8'h00, 2'd2, 8'hFF, 0);
      send_item(OP_GOTO, 8'h00, 2'd3, 8'h80, 0);
      send_item(OP_GOTO, 8'hFF, 2'd1, 8'h7F, 0);
      send_item(OP_DISPLAY_ON, 8'h00, 2'd0, 8'h00, 0);
      send_item(OP_DISPLAY_OFF, 8'hFF, 2'd3, 8'hFF, 0);
      send_item(OP_CURSOR_AT, 8'h00, 2'd2, 8'h05, 0);
      send_item(OP_CURSOR_AT, 8'h00, 2'd0, 8'hFF, 0);
      send_item(OP_CURSOR_OFF, 8'h00, 2'd0, 8'h00, 0);
      send_item(OP_CLEAR, 8'h00, 2'd0, 8'h00, 0);
      send_item(OP_BACKLIGHT, 8'h01, 2'd0, 8'h00, 0);
      send_item(OP_CHAR, 8'h5A, 2'd0, 8'h00, 0);
      send_item(OP_BACKLIGHT, 8'hFE, 2'd0, 8'h00, 0);
      send_item(OP_FIRST_UNUSED, 8'hFF, 2'd3, 8'hFF, 0);
      send_item(OP_LAST_CODE, 8'h01, 2'd2, 8'h10, 0);
      send_item(OP_BACKLIGHT, 8'hFF, 2'd0, 8'h00, 0);
      send_item(OP_COMMAND, 8'h3C, 2'd0, 8'h00, 0);
   endtask

   initial begin
      int hold_left;
      int hold_seen;
      strobe_t got;
      hold_left     = 0;
      hold_seen     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.strobe_res, rsp_bus.reg_select, rsp_bus.nibble,
                   rsp_bus.wait_cycles, rsp_bus.backlight, rsp_bus.last};
            board.check_strobe(got);
         end
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      int gap_pct;
      board              = new();
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.operation  = OP_INIT;
      req_bus.byte_value = '0;
      req_bus.row        = '0;
      req_bus.column     = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_SHORT_WAIT;
      csr_bus.data       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle_idle();
         case (p)
            0: write_units(16'd1, 16'hFFFF);
            1: write_units(16'hFFFF, 16'd1);
            2: write_units(16'd0, 16'd0);
            3: write_units(UNIT_W'($urandom_range(1, 65535)), UNIT_W'($urandom_range(1, 65535)));
            default: write_units(SHORT_WAIT_RESET, LONG_WAIT_RESET);
         endcase
         case (p)
            0: begin
               gap_pct = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               gap_pct = 47;
               rsp_stall_pct <= 0;
            end
            2: begin
               gap_pct = 0;
               rsp_stall_pct <= 47;
            end
            default: begin
               gap_pct = 13;
               rsp_stall_pct <= 13;
            end
         endcase
         send_random_requests(ITEMS_PER_PHASE, gap_pct);
      end

      hold_requests <= hold_requests + 1;
      send_random_requests(8, 0);
      settle_idle();

      board.close();
      $display("Ran %0d requests (%0d with unused codes) over %0d wait settings.",
               requests_sent, ignored_sent, settings_used);
      $display("Checked %0d strobes, with idling mixes and a %0d-cycle output hold-off.",
               board.checked, LONG_HOLD);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: run timed out", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule
